### sv/bgt_pkg.sv
package bgt_pkg;

  localparam int MAX_POINTS = 256;
  localparam int QBITS      = 17;   // quotient bits of the shared divider
  localparam int NBITS      = 26;   // dividend bits
  localparam int DBITS      = 9;    // divisor bits (twice the step count)
  localparam int IBITS      = 19;   // corner index bits

  localparam logic [2:0] FACE_FRONT  = 3'd0;
  localparam logic [2:0] FACE_RIGHT  = 3'd1;
  localparam logic [2:0] FACE_LEFT   = 3'd2;
  localparam logic [2:0] FACE_BACK   = 3'd3;
  localparam logic [2:0] FACE_BOTTOM = 3'd4;
  localparam logic [2:0] FACE_TOP    = 3'd5;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEPTH  = 3'd2;
  localparam logic [2:0] REG_PTS_X  = 3'd3;
  localparam logic [2:0] REG_PTS_Y  = 3'd4;
  localparam logic [2:0] REG_PTS_Z  = 3'd5;

  // divider lanes
  localparam int LANE_RAMP_U = 0;
  localparam int LANE_RAMP_V = 1;
  localparam int LANE_TEX_U  = 2;
  localparam int LANE_TEX_V  = 3;

  // bias added so every ramp dividend stays positive: q' = q + RAMP_BIAS
  localparam logic [17:0] RAMP_BIAS = 18'd32769;

  typedef struct packed {
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] box_depth;
    logic [8:0]  points_x;
    logic [8:0]  points_y;
    logic [8:0]  points_z;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                  face;
    logic signed [15:0]          fixed_c;
    logic [3:0][IBITS-1:0]       corner;
    logic                        quad_valid;
    logic                        in_range;
  } side_t;

  typedef struct packed {
    side_t                       side;
    logic [1:0][DBITS-1:0]       dvs;
    logic [3:0][NBITS-1:0]       rem;
    logic [3:0][QBITS-1:0]       quo;
  } item_t;

  function automatic logic [8:0] eff_points(input logic [8:0] r);
    logic [8:0] res;
    if (r < 9'd2) begin
      res = 9'd2;
    end else if (r > 9'(MAX_POINTS)) begin
      res = 9'(MAX_POINTS);
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

### sv/bgt_front.sv
module bgt_front (
  input  logic               clk,
  input  logic               rst,
  input  bgt_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         face,
  input  logic [7:0]         col,
  input  logic [7:0]         row,
  output logic               out_valid,
  input  logic               out_ready,
  output bgt_pkg::item_t     out_item
);
  import bgt_pkg::*;

  // stage A registers
  logic               vld_a;
  logic               rdy_a;
  logic [2:0]         face_a;
  logic [7:0]         col_a;
  logic               in_range_a;
  logic               quad_a;
  logic [8:0]         nc_a;
  logic [7:0]         ku_a;
  logic [7:0]         kv_a;
  logic [7:0]         tu_a;
  logic [7:0]         tv_a;
  logic               sgn_u_a;
  logic               sgn_v_a;
  logic [23:0]        tl_u_a;
  logic [23:0]        tl_v_a;
  logic [23:0]        lk_u_a;
  logic [23:0]        lk_v_a;
  logic [24:0]        kb_u_a;
  logic [24:0]        kb_v_a;
  logic signed [15:0] fixed_a;
  logic [17:0]        area_xy_a;
  logic [17:0]        area_zy_a;
  logic [17:0]        area_xz_a;
  logic [16:0]        rownc_a;

  // stage A combinational
  logic [8:0]         px;
  logic [8:0]         py;
  logic [8:0]         pz;
  logic [8:0]         nc;
  logic [8:0]         nr;
  logic [7:0]         ku;
  logic [7:0]         kv;
  logic [15:0]        len_u;
  logic [15:0]        len_v;
  logic [15:0]        len_c;
  logic               sgn_u;
  logic               sgn_v;
  logic               sgn_c;
  logic [16:0]        half_up;
  logic signed [15:0] fixed_c;
  logic               face_ok;
  logic               in_rng;

  always_comb begin
    px = eff_points(cfg.points_x);
    py = eff_points(cfg.points_y);
    pz = eff_points(cfg.points_z);
    nc = (face == FACE_RIGHT || face == FACE_LEFT) ? pz : px;
    nr = (face == FACE_BOTTOM || face == FACE_TOP) ? pz : py;
    ku = 8'(nc - 9'd1);
    kv = 8'(nr - 9'd1);
    len_u = (face == FACE_RIGHT || face == FACE_LEFT) ? cfg.box_depth : cfg.box_width;
    len_v = (face == FACE_BOTTOM || face == FACE_TOP) ? cfg.box_depth : cfg.box_height;
    sgn_u = (face == FACE_RIGHT || face == FACE_BACK);
    sgn_v = (face == FACE_TOP);
    unique case (face)
      FACE_FRONT:  begin len_c = cfg.box_depth;  sgn_c = 1'b0; end
      FACE_RIGHT:  begin len_c = cfg.box_width;  sgn_c = 1'b0; end
      FACE_LEFT:   begin len_c = cfg.box_width;  sgn_c = 1'b1; end
      FACE_BACK:   begin len_c = cfg.box_depth;  sgn_c = 1'b1; end
      FACE_BOTTOM: begin len_c = cfg.box_height; sgn_c = 1'b1; end
      default:     begin len_c = cfg.box_height; sgn_c = 1'b0; end
    endcase
    // half extent rounded half up, positive side saturates
    half_up = ({1'b0, len_c} + 17'd1) >> 1;
    if (sgn_c) begin
      fixed_c = -$signed({1'b0, len_c[15:1]});
    end else if (half_up > 17'd32767) begin
      fixed_c = 16'sd32767;
    end else begin
      fixed_c = $signed(half_up[15:0]);
    end
    face_ok = (face <= FACE_TOP);
    in_rng  = face_ok && ({1'b0, col} < nc) && ({1'b0, row} < nr);
  end

  logic in_ready_b;

  assign rdy_a    = !vld_a || in_ready_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (rdy_a) begin
      vld_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      face_a     <= face;
      col_a      <= col;
      in_range_a <= in_rng;
      quad_a     <= in_rng && ({1'b0, col} < nc - 9'd1) && ({1'b0, row} < nr - 9'd1);
      nc_a       <= nc;
      ku_a       <= ku;
      kv_a       <= kv;
      tu_a       <= col;
      tv_a       <= row;
      sgn_u_a    <= sgn_u;
      sgn_v_a    <= sgn_v;
      tl_u_a     <= col * len_u;
      tl_v_a     <= row * len_v;
      lk_u_a     <= len_u * ku;
      lk_v_a     <= len_v * kv;
      kb_u_a     <= {1'b0, ku, 16'd0} + {16'd0, ku, 1'b0} + {17'd0, ku};
      kb_v_a     <= {1'b0, kv, 16'd0} + {16'd0, kv, 1'b0} + {17'd0, kv};
      fixed_a    <= fixed_c;
      area_xy_a  <= 18'(px * py);
      area_zy_a  <= 18'(pz * py);
      area_xz_a  <= 18'(px * pz);
      rownc_a    <= row * nc;
    end
  end

  // stage B combinational
  logic signed [26:0]   num_u;
  logic signed [26:0]   num_v;
  logic [IBITS-1:0]     offset;
  logic [IBITS-1:0]     idx_a;
  logic [IBITS-1:0]     xy;
  logic [IBITS-1:0]     zy;
  logic [IBITS-1:0]     xz;
  item_t                item_b;

  always_comb begin
    num_u = sgn_u_a
      ? $signed({2'b0, kb_u_a}) + $signed({3'b0, lk_u_a}) - $signed({2'b0, tl_u_a, 1'b0})
      : $signed({2'b0, kb_u_a}) - $signed({3'b0, lk_u_a}) + $signed({2'b0, tl_u_a, 1'b0});
    num_v = sgn_v_a
      ? $signed({2'b0, kb_v_a}) + $signed({3'b0, lk_v_a}) - $signed({2'b0, tl_v_a, 1'b0})
      : $signed({2'b0, kb_v_a}) - $signed({3'b0, lk_v_a}) + $signed({2'b0, tl_v_a, 1'b0});
    xy = {1'b0, area_xy_a};
    zy = {1'b0, area_zy_a};
    xz = {1'b0, area_xz_a};
    unique case (face_a)
      FACE_FRONT:  offset = '0;
      FACE_RIGHT:  offset = xy;
      FACE_LEFT:   offset = xy + zy;
      FACE_BACK:   offset = xy + (zy << 1);
      FACE_BOTTOM: offset = (xy << 1) + (zy << 1);
      default:     offset = (xy << 1) + (zy << 1) + xz;
    endcase
    idx_a = offset + {2'b0, rownc_a} + {11'd0, col_a};

    item_b.side.face       = face_a;
    item_b.side.fixed_c    = fixed_a;
    item_b.side.in_range   = in_range_a;
    item_b.side.quad_valid = quad_a;
    item_b.side.corner[0]  = idx_a;
    item_b.side.corner[1]  = quad_a ? idx_a + 19'd1 : '0;
    item_b.side.corner[2]  = quad_a ? idx_a + {10'd0, nc_a} : '0;
    item_b.side.corner[3]  = quad_a ? idx_a + {10'd0, nc_a} + 19'd1 : '0;
    item_b.dvs[0] = {ku_a, 1'b0};
    item_b.dvs[1] = {kv_a, 1'b0};
    item_b.rem[LANE_RAMP_U] = num_u[NBITS-1:0];
    item_b.rem[LANE_RAMP_V] = num_v[NBITS-1:0];
    item_b.rem[LANE_TEX_U]  = {2'b0, tu_a, 16'd0} + {18'd0, ku_a};
    item_b.rem[LANE_TEX_V]  = {2'b0, tv_a, 16'd0} + {18'd0, kv_a};
    item_b.quo = '0;
  end

  assign in_ready_b = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready_b) begin
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready_b && vld_a) begin
      out_item <= item_b;
    end
  end

endmodule

### sv/bgt_div_stage.sv
module bgt_div_stage #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bgt_pkg::item_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output bgt_pkg::item_t   out_item
);
  import bgt_pkg::*;

  item_t            nxt;
  logic [NBITS-1:0] dsh;

  // one restoring step per lane: try to take divisor << BIT off the remainder
  always_comb begin
    nxt = in_item;
    for (int l = 0; l < 4; l++) begin
      dsh = NBITS'(in_item.dvs[l % 2]) << BIT;
      if (in_item.rem[l] >= dsh) begin
        nxt.rem[l]      = in_item.rem[l] - dsh;
        nxt.quo[l][BIT] = 1'b1;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= nxt;
    end
  end

endmodule

### sv/box_grid_tessellator_top.sv
// Box grid tessellator: one vertex of a subdivided box per input transaction.
// Slave stream carries face, column and row; master stream returns position
// (signed Q8.8), texture coordinate (Q1.15), normal code, the four corner
// indices of the quad starting at that vertex, and the quad/range flags.
// Box size and grid point counts sit in six registers on the cfg_* write
// port; write them only while no transaction is in flight.
// A result reaches the master side through twenty register stages: two
// setup stages (face selection and products), seventeen stages of the
// shared four-lane restoring divider (one quotient bit per stage), and the
// output register. Throughput is one transaction per cycle while the
// receiver keeps taking results.
// Every stage has its own valid bit and takes new data when it is empty or
// its successor advances, so a stalled receiver fills the pipeline without
// dropping or repeating anything; s_tready falls only when every stage holds
// a transaction. Reset empties the pipeline and restores a 1.0 cube with two
// points per edge.
module box_grid_tessellator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // face[2:0], col[10:3], row[18:11]
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, normal_code, corner_a..corner_d,
  // quad_valid, in_range
  output logic [167:0] m_tdata
);
  import bgt_pkg::*;

  localparam int NSTAGE = QBITS;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_width  <= 16'd256;
      cfg.box_height <= 16'd256;
      cfg.box_depth  <= 16'd256;
      cfg.points_x   <= 9'd2;
      cfg.points_y   <= 9'd2;
      cfg.points_z   <= 9'd2;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_WIDTH:  cfg.box_width  <= cfg_wdata;
        REG_HEIGHT: cfg.box_height <= cfg_wdata;
        REG_DEPTH:  cfg.box_depth  <= cfg_wdata;
        REG_PTS_X:  cfg.points_x   <= cfg_wdata[8:0];
        REG_PTS_Y:  cfg.points_y   <= cfg_wdata[8:0];
        REG_PTS_Z:  cfg.points_z   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic  [NSTAGE:0] vld;
  logic  [NSTAGE:0] rdy;
  item_t            itm [NSTAGE+1];

  bgt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .face      (s_tdata[2:0]),
    .col       (s_tdata[10:3]),
    .row       (s_tdata[18:11]),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_item  (itm[0])
  );

  for (genvar i = 0; i < NSTAGE; i++) begin : g_div
    bgt_div_stage #(.BIT(NSTAGE - 1 - i)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_item   (itm[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_item  (itm[i+1])
    );
  end

  // final: remove the ramp bias, saturate, place on axes, zero out-of-range words
  item_t              fin;
  logic signed [18:0] ru_w;
  logic signed [18:0] rv_w;
  logic signed [15:0] ru;
  logic signed [15:0] rv;
  logic signed [15:0] px_o;
  logic signed [15:0] py_o;
  logic signed [15:0] pz_o;
  logic [167:0]       data_next;

  always_comb begin
    fin  = itm[NSTAGE];
    ru_w = $signed({2'b0, fin.quo[LANE_RAMP_U]}) - $signed({1'b0, RAMP_BIAS});
    rv_w = $signed({2'b0, fin.quo[LANE_RAMP_V]}) - $signed({1'b0, RAMP_BIAS});
    if (ru_w > 19'sd32767) begin
      ru = 16'sd32767;
    end else if (ru_w < -19'sd32768) begin
      ru = -16'sd32768;
    end else begin
      ru = ru_w[15:0];
    end
    if (rv_w > 19'sd32767) begin
      rv = 16'sd32767;
    end else if (rv_w < -19'sd32768) begin
      rv = -16'sd32768;
    end else begin
      rv = rv_w[15:0];
    end
    unique case (fin.side.face)
      FACE_FRONT, FACE_BACK: begin
        px_o = ru; py_o = rv; pz_o = fin.side.fixed_c;
      end
      FACE_RIGHT, FACE_LEFT: begin
        px_o = fin.side.fixed_c; py_o = rv; pz_o = ru;
      end
      default: begin
        px_o = ru; py_o = fin.side.fixed_c; pz_o = rv;
      end
    endcase
    data_next = '0;
    if (fin.side.in_range) begin
      data_next[15:0]    = px_o;
      data_next[31:16]   = py_o;
      data_next[47:32]   = pz_o;
      data_next[63:48]   = fin.quo[LANE_TEX_U][15:0];
      data_next[79:64]   = fin.quo[LANE_TEX_V][15:0];
      data_next[82:80]   = fin.side.face;
      data_next[101:83]  = fin.side.corner[0];
      data_next[120:102] = fin.side.corner[1];
      data_next[139:121] = fin.side.corner[2];
      data_next[158:140] = fin.side.corner[3];
      data_next[159]     = fin.side.quad_valid;
      data_next[160]     = 1'b1;
    end
  end

  assign rdy[NSTAGE] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy[NSTAGE]) begin
      m_tvalid <= vld[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTAGE] && vld[NSTAGE]) begin
      m_tdata <= data_next;
    end
  end

endmodule
